// ===== hw/rtl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared item types, field widths and register codes.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int CMD_W   = 16;
  localparam int GF_W    = 16;
  localparam int LIM_W   = 15;
  localparam int WHEEL_W = 24;
  localparam int MAG_W   = 23;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = MAG_W + LIM_W;

  localparam logic signed [CMD_W-1:0] CMD_LIMIT = 16'sd25600;

  localparam logic [GF_W-1:0]  GF_RESET  = 16'd256;
  localparam logic [LIM_W-1:0] LIM_RESET = 15'd25600;

  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  localparam logic [0:0] REG_GEOMETRIC = 1'b0;
  localparam logic [0:0] REG_MAX_SPEED = 1'b1;

  typedef struct packed {
    logic signed [CMD_W-1:0] vel_x;
    logic signed [CMD_W-1:0] vel_y;
    logic signed [CMD_W-1:0] turn_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] front_left;
    logic signed [WHEEL_W-1:0] front_right;
    logic signed [WHEEL_W-1:0] rear_left;
    logic signed [WHEEL_W-1:0] rear_right;
    logic                      was_scaled;
  } res_t;

  typedef logic [3:0][WHEEL_W-1:0] wheels_t;
  typedef logic [3:0][MAG_W-1:0]   mags_t;

  typedef struct packed {
    logic             valid;
    logic             scaled;
    logic [MAG_W-1:0] peak;
  } peak_info_t;

endpackage

// ===== hw/rtl/mecanum_wheel_mixer_top.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Inverse kinematics for a mecanum base with uniform speed normalization.
// ----------------------------------------------------------------------------
// The block takes one motion command per clock while the output buffer has
// room and returns the four wheel speeds through the kinematics, the peak
// search and the 15-stage divider that scales the wheels down to max_speed, one quotient bit
// per stage. Commands are accepted whenever the two-entry output buffer has
// room, so a stalled result holds the pipeline only once both entries are full.
// Configuration registers are written through the APB port; the user must write
// them only while no item is in flight, as the block does not enforce it.
module mecanum_wheel_mixer_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  mwm_pkg::cmd_t        cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mwm_pkg::res_t        res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mwm_pkg::*;

  logic [GF_W-1:0]  geometric_factor;
  logic [LIM_W-1:0] max_speed;
  logic             en;
  logic             kin_valid;
  wheels_t          kin_wheels;
  peak_info_t       info;
  wheels_t          pk_wheels;
  mags_t            pk_mags;
  logic             div_valid;
  res_t             div_res;
  logic             skid_valid;
  res_t             skid;
  logic             push, pop;

  assign pready    = 1'b1;
  assign en        = !(res_valid && skid_valid);
  assign cmd_ready = en && !rst;
  assign push      = en && div_valid;
  assign pop       = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      geometric_factor <= GF_RESET;
      max_speed        <= LIM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GEOMETRIC: geometric_factor <= pwdata[GF_W-1:0];
        REG_MAX_SPEED: max_speed        <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GEOMETRIC: prdata = {{(32-GF_W){1'b0}}, geometric_factor};
      REG_MAX_SPEED: prdata = {{(32-LIM_W){1'b0}}, max_speed};
      default:       prdata = '0;
    endcase
  end

  mwm_kin u_kin (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .geometric_factor (geometric_factor),
    .wheel_valid      (kin_valid),
    .wheels           (kin_wheels)
  );

  mwm_peak u_peak (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .wheel_valid (kin_valid),
    .wheels      (kin_wheels),
    .max_speed   (max_speed),
    .info        (info),
    .wheels_out  (pk_wheels),
    .mags_out    (pk_mags)
  );

  mwm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .info      (info),
    .wheels    (pk_wheels),
    .mags      (pk_mags),
    .max_speed (max_speed),
    .res_valid (div_valid),
    .res       (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        res_valid <= push;
      end
    end else if (!res_valid) begin
      res_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        res <= skid;
        if (push) begin
          skid <= div_res;
        end
      end else if (push) begin
        res <= div_res;
      end
    end else if (!res_valid) begin
      if (push) begin
        res <= div_res;
      end
    end else if (push) begin
      skid <= div_res;
    end
  end

`ifndef SYNTH
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without a head entry");
`endif

endmodule

// ===== hw/rtl/mwm_kin.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer kinematics
// Clamps the command, forms the rotation term and the four wheel speeds.
// ----------------------------------------------------------------------------
module mwm_kin (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       cmd_valid,
  input  mwm_pkg::cmd_t              cmd,
  input  logic [mwm_pkg::GF_W-1:0]   geometric_factor,
  output logic                       wheel_valid,
  output mwm_pkg::wheels_t           wheels
);
  import mwm_pkg::*;

  function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] v);
    if (v > CMD_LIMIT) begin
      return CMD_LIMIT;
    end else if (v < -CMD_LIMIT) begin
      return -CMD_LIMIT;
    end
    return v;
  endfunction

  logic                    v1, v2, v3;
  logic signed [CMD_W-1:0] x1, y1, w1, x2, y2;
  logic signed [32:0]      prod2;
  logic [32:0]             prod_mag;
  logic [WHEEL_W-1:0]      rot_mag, rot_next, r3;
  logic [CMD_W:0]          s3, d3;
  logic [WHEEL_W-1:0]      s3_ext, d3_ext;

  always_comb begin
    prod_mag = prod2[32] ? -prod2 : prod2;
    rot_mag  = {1'b0, prod_mag[30:8]};
    rot_next = prod2[32] ? -rot_mag : rot_mag;
    s3_ext   = {{(WHEEL_W-CMD_W-1){s3[CMD_W]}}, s3};
    d3_ext   = {{(WHEEL_W-CMD_W-1){d3[CMD_W]}}, d3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      wheel_valid <= 1'b0;
    end else if (en) begin
      v1          <= cmd_valid;
      v2          <= v1;
      v3          <= v2;
      wheel_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= clamp_cmd(cmd.vel_x);
      y1    <= clamp_cmd(cmd.vel_y);
      w1    <= clamp_cmd(cmd.turn_rate);
      x2    <= x1;
      y2    <= y1;
      prod2 <= w1 * $signed({1'b0, geometric_factor});
      r3    <= rot_next;
      s3    <= {x2[CMD_W-1], x2} + {y2[CMD_W-1], y2};
      d3    <= {x2[CMD_W-1], x2} - {y2[CMD_W-1], y2};
      wheels[WHEEL_FL] <= d3_ext - r3;
      wheels[WHEEL_FR] <= s3_ext + r3;
      wheels[WHEEL_RL] <= s3_ext - r3;
      wheels[WHEEL_RR] <= d3_ext + r3;
    end
  end

`ifndef SYNTH
  a_wheel_sum: assert property (@(posedge clk) disable iff (rst)
    wheel_valid |-> (WHEEL_W'(wheels[WHEEL_FL] + wheels[WHEEL_FR]) ==
                     WHEEL_W'(wheels[WHEEL_RL] + wheels[WHEEL_RR])))
    else $error("front and rear wheel pairs disagree");
`endif

endmodule

// ===== hw/rtl/mwm_peak.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer peak search
// Finds the largest wheel magnitude and decides whether to scale.
// ----------------------------------------------------------------------------
module mwm_peak (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      wheel_valid,
  input  mwm_pkg::wheels_t          wheels,
  input  logic [mwm_pkg::LIM_W-1:0] max_speed,
  output mwm_pkg::peak_info_t       info,
  output mwm_pkg::wheels_t          wheels_out,
  output mwm_pkg::mags_t            mags_out
);
  import mwm_pkg::*;

  logic             v1, v2, v3;
  logic             scaled3;
  logic [MAG_W-1:0] peak3;
  wheels_t          wheels1, wheels2;
  mags_t            mag_next, mags1, mags2;
  logic [MAG_W-1:0] m01, m23, peak_next;

  always_comb begin
    logic [WHEEL_W-1:0] neg;
    for (int i = 0; i < 4; i++) begin
      neg         = -wheels[i];
      mag_next[i] = wheels[i][WHEEL_W-1] ? neg[MAG_W-1:0] : wheels[i][MAG_W-1:0];
    end
    peak_next = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= wheel_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wheels1    <= wheels;
      mags1      <= mag_next;
      wheels2    <= wheels1;
      mags2      <= mags1;
      m01        <= (mags1[0] > mags1[1]) ? mags1[0] : mags1[1];
      m23        <= (mags1[2] > mags1[3]) ? mags1[2] : mags1[3];
      wheels_out <= wheels2;
      mags_out   <= mags2;
      peak3      <= peak_next;
      scaled3    <= peak_next > {{(MAG_W-LIM_W){1'b0}}, max_speed};
    end
  end

  assign info = '{valid: v3, scaled: scaled3, peak: peak3};

`ifndef SYNTH
  a_scaled_peak: assert property (@(posedge clk) disable iff (rst)
    (info.valid && info.scaled) |-> (info.peak != '0))
    else $error("scaling chosen with a zero peak");
`endif

endmodule

// ===== hw/rtl/mwm_div.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer scaler
// Multiplies each wheel magnitude by the limit and divides by the peak,
// one quotient bit per stage, then restores the sign; unscaled wheels pass through.
// ----------------------------------------------------------------------------
module mwm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  mwm_pkg::peak_info_t       info,
  input  mwm_pkg::wheels_t          wheels,
  input  mwm_pkg::mags_t            mags,
  input  logic [mwm_pkg::LIM_W-1:0] max_speed,
  output logic                      res_valid,
  output mwm_pkg::res_t             res
);
  import mwm_pkg::*;

  logic                       v_s      [QUO_W+1];
  logic                       scaled_s [QUO_W+1];
  logic [MAG_W-1:0]           peak_s   [QUO_W+1];
  wheels_t                    wheels_s [QUO_W+1];
  logic [3:0][NUM_W-1:0]      rem_s    [QUO_W+1];
  logic [3:0][QUO_W-1:0]      quo_s    [QUO_W+1];
  wheels_t                    final_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        v_s[k] <= 1'b0;
      end
    end else if (en) begin
      v_s[0] <= info.valid;
      for (int k = 0; k < QUO_W; k++) begin
        v_s[k+1] <= v_s[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] dvs;
    if (en) begin
      scaled_s[0] <= info.scaled;
      peak_s[0]   <= info.peak;
      wheels_s[0] <= wheels;
      for (int l = 0; l < 4; l++) begin
        rem_s[0][l] <= NUM_W'(mags[l]) * NUM_W'(max_speed);
        quo_s[0][l] <= '0;
      end
      for (int k = 0; k < QUO_W; k++) begin
        scaled_s[k+1] <= scaled_s[k];
        peak_s[k+1]   <= peak_s[k];
        wheels_s[k+1] <= wheels_s[k];
        dvs = NUM_W'(peak_s[k]) << (QUO_W - 1 - k);
        for (int l = 0; l < 4; l++) begin
          if (rem_s[k][l] >= dvs) begin
            rem_s[k+1][l] <= rem_s[k][l] - dvs;
            quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], 1'b1};
          end else begin
            rem_s[k+1][l] <= rem_s[k][l];
            quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    logic [WHEEL_W-1:0] qext;
    for (int l = 0; l < 4; l++) begin
      qext = {{(WHEEL_W-QUO_W){1'b0}}, quo_s[QUO_W][l]};
      if (scaled_s[QUO_W]) begin
        final_w[l] = wheels_s[QUO_W][l][WHEEL_W-1] ? -qext : qext;
      end else begin
        final_w[l] = wheels_s[QUO_W][l];
      end
    end
  end

  assign res_valid       = v_s[QUO_W];
  assign res.front_left  = final_w[WHEEL_FL];
  assign res.front_right = final_w[WHEEL_FR];
  assign res.rear_left   = final_w[WHEEL_RL];
  assign res.rear_right  = final_w[WHEEL_RR];
  assign res.was_scaled  = scaled_s[QUO_W];

`ifndef SYNTH
  a_rem_below_peak: assert property (@(posedge clk) disable iff (rst)
    (v_s[QUO_W] && scaled_s[QUO_W]) |->
      ((rem_s[QUO_W][0] < NUM_W'(peak_s[QUO_W])) &&
       (rem_s[QUO_W][3] < NUM_W'(peak_s[QUO_W]))))
    else $error("division remainder not below the peak");
`endif

endmodule

// ===== tb/tb_mecanum_wheel_mixer_top.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives motion commands through the valid/ready input channel, predicts the
// four wheel speeds and the scaling flag for each accepted item (or takes them
// from the directed table) and checks them in order against the output channel.
// Geometry and speed limit are set through the APB port between phases and
// read back. The run starts with a short directed table, then random phases
// that sweep several register settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_mecanum_wheel_mixer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  localparam longint CMD_CAP     = 25600;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     PHASE_ITEMS = 181;

  typedef struct {
    cmd_t c;
    bit   known;
    res_t r;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [GF_W-1:0]  geom_factor;
  logic [LIM_W-1:0] speed_cap;
  res_t             wheel_speeds_q[$];
  res_t             oldest;
  int               mismatch_count;
  int               cycle_count;
  int               idle_pct;
  int               stall_pct;
  row_t             directed[$];
  int               idle_table[4];
  int               stall_table[4];

  mecanum_wheel_mixer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clamp_cmd(input logic signed [CMD_W-1:0] v);
    longint s;
    s = v;
    if (s > CMD_CAP) begin
      s = CMD_CAP;
    end else if (s < -CMD_CAP) begin
      s = -CMD_CAP;
    end
    return s;
  endfunction

  function automatic res_t mix_wheels(input cmd_t c);
    longint vx, vy, vw, g, lim, prod, r, peak, m;
    longint wh[4];
    res_t   o;
    vx = clamp_cmd(c.vel_x);
    vy = clamp_cmd(c.vel_y);
    vw = clamp_cmd(c.turn_rate);
    g = geom_factor;
    lim = speed_cap;
    prod = vw * g;
    r = (prod < 0) ? -((-prod) / 256) : prod / 256;
    wh[WHEEL_FL] = vx - vy - r;
    wh[WHEEL_FR] = vx + vy + r;
    wh[WHEEL_RL] = vx + vy - r;
    wh[WHEEL_RR] = vx - vy + r;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      m = (wh[i] < 0) ? -wh[i] : wh[i];
      if (m > peak) begin
        peak = m;
      end
    end
    o.was_scaled = (peak > lim);
    if (o.was_scaled) begin
      for (int i = 0; i < 4; i++) begin
        wh[i] = (wh[i] * lim) / peak;
      end
    end
    o.front_left  = wh[WHEEL_FL][WHEEL_W-1:0];
    o.front_right = wh[WHEEL_FR][WHEEL_W-1:0];
    o.rear_left   = wh[WHEEL_RL][WHEEL_W-1:0];
    o.rear_right  = wh[WHEEL_RR][WHEEL_W-1:0];
    return o;
  endfunction

  function automatic row_t make_row(input int x, input int y, input int w, input bit known,
                                    input int fl, input int fr, input int rl, input int rr,
                                    input bit s);
    row_t v;
    v.c.vel_x = x[CMD_W-1:0];
    v.c.vel_y = y[CMD_W-1:0];
    v.c.turn_rate = w[CMD_W-1:0];
    v.known = known;
    v.r.front_left = fl[WHEEL_W-1:0];
    v.r.front_right = fr[WHEEL_W-1:0];
    v.r.rear_left = rl[WHEEL_W-1:0];
    v.r.rear_right = rr[WHEEL_W-1:0];
    v.r.was_scaled = s;
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pick_field();
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: begin
        case ($urandom_range(0, 7))
          0: v = 25600;
          1: v = -25600;
          2: v = 25601;
          3: v = -25601;
          4: v = 32767;
          5: v = -32768;
          6: v = 1;
          default: v = -1;
        endcase
      end
      2, 3: v = $urandom_range(0, 65535);
      default: v = $urandom_range(0, 51200) - 25600;
    endcase
    return v[CMD_W-1:0];
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic set_reg(input logic [0:0] code, input logic [31:0] value);
    logic [31:0] readback;
    if (code == REG_GEOMETRIC) begin
      readback = {16'd0, value[GF_W-1:0]};
      geom_factor = value[GF_W-1:0];
    end else begin
      readback = {17'd0, value[LIM_W-1:0]};
      speed_cap = value[LIM_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {code, 2'b00};
    pwdata <= readback;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback) begin
      report($sformatf("register %0d read %0d, wrote %0d", code, prdata, readback));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_cmd(input cmd_t c, input res_t exp);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    wheel_speeds_q.push_back(exp);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (wheel_speeds_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int gf, input int lim, input int mode, input int n);
    cmd_t c;
    wait_drained();
    set_reg(REG_GEOMETRIC, gf);
    set_reg(REG_MAX_SPEED, lim);
    idle_pct = idle_table[mode];
    stall_pct = stall_table[mode];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        c = '0;
      end else begin
        c.vel_x = pick_field();
        c.vel_y = pick_field();
        c.turn_rate = pick_field();
      end
      send_cmd(c, mix_wheels(c));
    end
    cmd_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (wheel_speeds_q.size() == 0) begin
        report($sformatf("unexpected result fl=%0d fr=%0d rl=%0d rr=%0d s=%0d",
                         res.front_left, res.front_right, res.rear_left,
                         res.rear_right, res.was_scaled));
      end else begin
        oldest = wheel_speeds_q.pop_front();
        if (res.front_left !== oldest.front_left || res.front_right !== oldest.front_right ||
            res.rear_left !== oldest.rear_left || res.rear_right !== oldest.rear_right ||
            res.was_scaled !== oldest.was_scaled) begin
          report($sformatf("expected %0d %0d %0d %0d s=%0d, got %0d %0d %0d %0d s=%0d",
                           oldest.front_left, oldest.front_right, oldest.rear_left,
                           oldest.rear_right, oldest.was_scaled, res.front_left,
                           res.front_right, res.rear_left, res.rear_right,
                           res.was_scaled));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    res_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    geom_factor = GF_RESET;
    speed_cap = LIM_RESET;
    idle_table = '{0, 71, 0, 19};
    stall_table = '{0, 0, 71, 19};

    directed.push_back(make_row(0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_row(32767, 0, 0, 1, 25600, 25600, 25600, 25600, 0));
    directed.push_back(make_row(-32768, 0, 0, 1, -25600, -25600, -25600, -25600, 0));
    directed.push_back(make_row(25600, 25600, 0, 1, 0, 25600, 25600, 0, 1));
    directed.push_back(make_row(0, 0, 25600, 1, -25600, 25600, -25600, 25600, 0));
    directed.push_back(make_row(0, -32768, 0, 1, 25600, -25600, -25600, 25600, 0));
    directed.push_back(make_row(0, 0, -32768, 1, 25600, -25600, 25600, -25600, 0));
    directed.push_back(make_row(25600, -25600, -25600, 1, 25600, -8533, 8533, 8533, 1));
    directed.push_back(make_row(25601, -25601, 25601, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(1, -1, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(-1, -1, -1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(21845, -21846, 21845, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(-21846, 21845, -21846, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(25599, 25599, 25599, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(-25600, 25600, 100, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(32767, 32767, 32767, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_cmd(directed[i].c, directed[i].known ? directed[i].r : mix_wheels(directed[i].c));
    end
    cmd_valid <= 1'b0;

    run_phase(256, 25600, 0, PHASE_ITEMS);
    run_phase(0, 1, 1, PHASE_ITEMS);
    run_phase(65535, 32767, 2, PHASE_ITEMS);
    run_phase(65535, 0, 3, PHASE_ITEMS);
    run_phase(1, 12800, 0, PHASE_ITEMS);
    run_phase($urandom_range(0, 65535), $urandom_range(1, 32767), 1, PHASE_ITEMS);
    run_phase(512, 25600, 2, PHASE_ITEMS);
    run_phase($urandom_range(0, 65535), $urandom_range(1, 32767), 3, PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
